[hdl/wdb_pkg.sv]
// Shared types and constants for the watchdog bank.
package wdb_pkg;

  localparam int unsigned DEFAULT_COUNT_RESET = 100;
  localparam int unsigned MAX_NOTICES = 16;
  localparam int unsigned NCNT_W = 5;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_FEED     = 2'd1,
    OP_QUERY    = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ASSIGNED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_ONLINE   = 2'd2,
    KIND_EXPIRED  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FEED_WR,
    ST_QUERY_RES,
    ST_TICK,
    ST_TICK_END
  } state_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] reload;
    logic [7:0]  owner;
    logic        notify;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [7:0]  owner_tag;
    logic [15:0] reload_value;
    logic [15:0] start_value;
    logic        notify;
  } item_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [3:0]  slot_out;
    logic [7:0]  owner_out;
    logic        online;
    logic        last;
  } result_t;

endpackage

[hdl/wdb_slot_mem.sv]
// Single-port-per-direction slot memory with registered read data.
module wdb_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic            clk,
  input  logic [AW-1:0]   rd_addr,
  output wdb_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  wdb_pkg::entry_t wr_data
);

  wdb_pkg::entry_t mem [DEPTH];
  wdb_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/wdb_ctrl.sv]
// Operation sequencer: decodes items and walks the slot memory on a tick.
module wdb_ctrl #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wdb_pkg::item_t   in_item,
  input  logic [15:0]      default_count,
  input  logic             out_free,
  output wdb_pkg::result_t push,
  output logic [IDX_W-1:0] rd_addr,
  input  wdb_pkg::entry_t  rd_data,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output wdb_pkg::entry_t  wr_data
);

  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;

  wdb_pkg::state_t state_r, state_nxt;
  wdb_pkg::item_t  item_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [wdb_pkg::NCNT_W-1:0] ncount_r, ncount_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [7:0]        pend_owner_r, pend_owner_nxt;

  logic [CMP_W-1:0]  slot_ext;
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_ok;
  logic              last_slot;
  logic              want;
  logic              stall;
  logic [CMP_W-1:0]  used_ext;
  logic [CMP_W-1:0]  pend_ext;

  assign slot_ext  = CMP_W'(item_r.slot);
  assign slot_idx  = slot_ext[IDX_W-1:0];
  assign slot_ok   = slot_ext < CMP_W'(used_r);
  assign used_ext  = CMP_W'(used_r);
  assign pend_ext  = CMP_W'(pend_slot_r);
  assign last_slot = (CNT_W'(idx_r) + CNT_W'(1)) == used_r;
  assign want      = (rd_data.count == 16'd0) && rd_data.notify &&
                     (ncount_r < wdb_pkg::NCNT_W'(wdb_pkg::MAX_NOTICES));
  // A new notice can only be parked once the one already parked has left.
  assign stall     = want && pend_valid_r && !out_free;
  assign in_ready  = (state_r == wdb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wdb_pkg::ST_IDLE;
      used_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    idx_r        <= idx_nxt;
    ncount_r     <= ncount_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_owner_r <= pend_owner_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    ncount_nxt     = ncount_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_owner_nxt = pend_owner_r;
    rd_addr        = slot_idx;
    wr_en          = 1'b0;
    wr_addr        = slot_idx;
    wr_data        = rd_data;
    push           = '0;
    push.kind      = wdb_pkg::KIND_ASSIGNED;
    push.last      = 1'b1;

    case (state_r)
      wdb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = wdb_pkg::ST_EXEC;
        end
      end

      wdb_pkg::ST_EXEC: begin
        case (wdb_pkg::op_t'(item_r.op))
          wdb_pkg::OP_REGISTER: begin
            if (out_free) begin
              push.valid = 1'b1;
              state_nxt  = wdb_pkg::ST_IDLE;
              if (used_r == CNT_W'(SLOTS)) begin
                push.kind = wdb_pkg::KIND_FULL;
              end else begin
                push.kind      = wdb_pkg::KIND_ASSIGNED;
                push.slot_out  = used_ext[3:0];
                wr_en          = 1'b1;
                wr_addr        = used_r[IDX_W-1:0];
                wr_data.count  = (item_r.start_value == 16'd0) ? default_count
                                                                : item_r.start_value;
                wr_data.reload = (item_r.reload_value == 16'd0) ? default_count
                                                                 : item_r.reload_value;
                wr_data.owner  = item_r.owner_tag;
                wr_data.notify = item_r.notify;
                used_nxt       = used_r + CNT_W'(1);
              end
            end
          end
          wdb_pkg::OP_FEED: begin
            state_nxt = slot_ok ? wdb_pkg::ST_FEED_WR : wdb_pkg::ST_IDLE;
          end
          wdb_pkg::OP_QUERY: begin
            if (slot_ok) begin
              state_nxt = wdb_pkg::ST_QUERY_RES;
            end else if (out_free) begin
              // Slots never registered are reported offline without a memory read.
              push.valid    = 1'b1;
              push.kind     = wdb_pkg::KIND_ONLINE;
              push.slot_out = item_r.slot;
              state_nxt     = wdb_pkg::ST_IDLE;
            end
          end
          wdb_pkg::OP_TICK: begin
            rd_addr        = '0;
            idx_nxt        = '0;
            ncount_nxt     = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = (used_r == '0) ? wdb_pkg::ST_IDLE : wdb_pkg::ST_TICK;
          end
          default: begin
            state_nxt = wdb_pkg::ST_IDLE;
          end
        endcase
      end

      wdb_pkg::ST_FEED_WR: begin
        wr_en         = 1'b1;
        wr_data.count = rd_data.reload;
        state_nxt     = wdb_pkg::ST_IDLE;
      end

      wdb_pkg::ST_QUERY_RES: begin
        if (out_free) begin
          push.valid    = 1'b1;
          push.kind     = wdb_pkg::KIND_ONLINE;
          push.slot_out = item_r.slot;
          push.online   = (rd_data.count != 16'd0);
          state_nxt     = wdb_pkg::ST_IDLE;
        end
      end

      wdb_pkg::ST_TICK: begin
        wr_addr = idx_r;
        if (stall) begin
          rd_addr = idx_r;
        end else begin
          if (rd_data.count != 16'd0) begin
            wr_en         = 1'b1;
            wr_data.count = rd_data.count - 16'd1;
          end
          if (want) begin
            if (pend_valid_r) begin
              push.valid     = 1'b1;
              push.kind      = wdb_pkg::KIND_EXPIRED;
              push.slot_out  = pend_ext[3:0];
              push.owner_out = pend_owner_r;
              push.last      = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = idx_r;
            pend_owner_nxt = rd_data.owner;
            ncount_nxt     = ncount_r + wdb_pkg::NCNT_W'(1);
          end
          if (last_slot) begin
            rd_addr   = idx_r;
            state_nxt = wdb_pkg::ST_TICK_END;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            rd_addr = idx_r + IDX_W'(1);
          end
        end
      end

      wdb_pkg::ST_TICK_END: begin
        if (!pend_valid_r) begin
          state_nxt = wdb_pkg::ST_IDLE;
        end else if (out_free) begin
          push.valid     = 1'b1;
          push.kind      = wdb_pkg::KIND_EXPIRED;
          push.slot_out  = pend_ext[3:0];
          push.owner_out = pend_owner_r;
          push.last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = wdb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wdb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/multi_channel_watchdog_bank.sv]
// Watchdog bank top level: stream ports, default count register, result register.
//
// A bank of SLOTS watchdog counters kept in one slot memory with a registered
// read. A tick walks the registered slots through the memory one slot per
// cycle, pausing while an expired notice waits on a stalled result port.
// Each expired notice is held back until the next one is found, so that the
// final one can carry tlast. The next item is accepted while the last result
// still sits in the output register.
module multi_channel_watchdog_bank #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // default_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,       // slot, owner_tag, reload_value, start_value, notify
  input  logic [1:0]  in_tuser,       // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,      // slot_out, owner_out, online
  output logic [1:0]  out_tuser,      // kind
  output logic        out_tlast
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  logic [15:0]       default_count_r;
  logic              out_valid_r, out_valid_nxt;
  wdb_pkg::result_t  out_r;
  wdb_pkg::result_t  push;
  wdb_pkg::item_t    in_item;
  logic              out_free;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  wdb_pkg::entry_t   rd_data;
  wdb_pkg::entry_t   wr_data;

  assign in_item.op           = in_tuser;
  assign in_item.slot         = in_tdata[3:0];
  assign in_item.owner_tag    = in_tdata[11:4];
  assign in_item.reload_value = in_tdata[27:12];
  assign in_item.start_value  = in_tdata[43:28];
  assign in_item.notify       = in_tdata[44];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_count_r <= 16'(wdb_pkg::DEFAULT_COUNT_RESET);
    end else if (cfg_we) begin
      default_count_r <= cfg_wdata;
    end
  end

  assign out_free      = !out_valid_r || out_tready;
  assign out_valid_nxt = push.valid ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_r <= push;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.online, out_r.owner_out, out_r.slot_out};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  wdb_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_item       (in_item),
    .default_count (default_count_r),
    .out_free      (out_free),
    .push          (push),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  wdb_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

[test/multi_channel_watchdog_bank_test.sv]
// Self-checking stream testbench for the watchdog bank with a built-in bank predictor.
`timescale 1ns / 1ps

module multi_channel_watchdog_bank_test;

  localparam int NUM_SLOTS = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    wdb_pkg::kind_t kind;
    logic [3:0]     slot;
    logic [7:0]     owner;
    logic           online;
    logic           last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Predicted state of the bank. Counters start at zero; the slot memory is not reset.
  logic [15:0] bank_count [NUM_SLOTS] = '{default: 16'd0};
  logic [15:0] bank_reload [NUM_SLOTS];
  logic [7:0]  bank_owner [NUM_SLOTS];
  logic        bank_notify [NUM_SLOTS];
  int          slots_taken = 0;
  logic [15:0] default_count = 16'(wdb_pkg::DEFAULT_COUNT_RESET);

  report_t due_reports[$];
  int      error_count = 0;
  int      cycle_count = 0;

  // Sender burst shaping and receiver stall pattern.
  int burst_left = 0;
  bit sender_steady = 0;
  int stall_mode = 0;
  int stall_left = 0;

  multi_channel_watchdog_bank #(.SLOTS(NUM_SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string field, int expected, int actual);
    error_count++;
    if (error_count <= 40)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_reports.size() == 0) begin
        error_count++;
        if (error_count <= 40)
          $display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
                   $time, out_tuser, out_tdata[3:0]);
      end else begin
        want = due_reports.pop_front();
        if (out_tuser != want.kind) report_mismatch("kind", want.kind, out_tuser);
        if (out_tdata[3:0] != want.slot) report_mismatch("slot", want.slot, out_tdata[3:0]);
        if (out_tdata[11:4] != want.owner)
          report_mismatch("owner", want.owner, out_tdata[11:4]);
        if (out_tdata[12] != want.online) report_mismatch("online", want.online, out_tdata[12]);
        if (out_tdata[15:13] != 3'b000) report_mismatch("tdata padding", 0, out_tdata[15:13]);
        if (out_tlast != want.last) report_mismatch("last", want.last, out_tlast);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_mode == 1 && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else if (stall_mode == 2 && $urandom_range(0, 9) < 6) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Applies one accepted item to the predicted bank and queues its results.
  task automatic bank_model_step(wdb_pkg::op_t op, logic [3:0] sl, logic [7:0] ow,
                                 logic [15:0] rl, logic [15:0] st, logic nt);
    report_t r;
    report_t notices[$];
    r.owner = '0;
    r.online = 1'b0;
    r.last = 1'b1;
    r.slot = '0;
    case (op)
      wdb_pkg::OP_REGISTER: begin
        if (slots_taken >= NUM_SLOTS) begin
          r.kind = wdb_pkg::KIND_FULL;
          due_reports.push_back(r);
        end else begin
          bank_owner[slots_taken] = ow;
          bank_reload[slots_taken] = (rl == 0) ? default_count : rl;
          bank_count[slots_taken] = (st == 0) ? default_count : st;
          bank_notify[slots_taken] = nt;
          r.kind = wdb_pkg::KIND_ASSIGNED;
          r.slot = 4'(slots_taken);
          slots_taken++;
          due_reports.push_back(r);
        end
      end
      wdb_pkg::OP_FEED: begin
        if (sl < slots_taken) bank_count[sl] = bank_reload[sl];
      end
      wdb_pkg::OP_QUERY: begin
        r.kind = wdb_pkg::KIND_ONLINE;
        r.slot = sl;
        r.online = (bank_count[sl] != 0);
        due_reports.push_back(r);
      end
      wdb_pkg::OP_TICK: begin
        for (int i = 0; i < slots_taken; i++) begin
          if (bank_count[i] != 0) begin
            bank_count[i] = bank_count[i] - 16'd1;
          end else if (bank_notify[i] && notices.size() < wdb_pkg::MAX_NOTICES) begin
            r.kind = wdb_pkg::KIND_EXPIRED;
            r.slot = 4'(i);
            r.owner = bank_owner[i];
            r.last = 1'b0;
            notices.push_back(r);
          end
        end
        if (notices.size() > 0) notices[notices.size() - 1].last = 1'b1;
        foreach (notices[k]) due_reports.push_back(notices[k]);
      end
    endcase
  endtask

  task automatic send_item(wdb_pkg::op_t op, logic [3:0] sl, logic [7:0] ow, logic [15:0] rl,
                           logic [15:0] st, logic nt);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, nt, st, rl, ow, sl};
    do @(posedge clk); while (!in_tready);
    bank_model_step(op, sl, ow, rl, st, nt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (!sender_steady) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Lets the bank drain completely, including ticks that end without a result.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_default_count(logic [15:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    default_count = value;
    @(posedge clk);
  endtask

  // Mostly short counts so that slots expire, with zeros and full-range values mixed in.
  function automatic logic [15:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return 16'd0;
    if (roll < 20) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 6));
  endfunction

  task automatic send_random_item(bit allow_register);
    logic [3:0]  sl;
    logic [7:0]  ow;
    logic [15:0] rl;
    logic [15:0] st;
    logic        nt;
    int          roll;
    sl = 4'($urandom);
    ow = 8'($urandom);
    rl = 16'($urandom);
    st = 16'($urandom);
    nt = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (allow_register && roll < 10) begin
      send_item(wdb_pkg::OP_REGISTER, sl, ow, pick_count(), pick_count(),
                $urandom_range(0, 3) != 0);
    end else if (roll < 45) begin
      send_item(wdb_pkg::OP_TICK, sl, ow, rl, st, nt);
    end else if (roll < 70) begin
      if (slots_taken > 0 && $urandom_range(0, 4) != 0)
        sl = 4'($urandom_range(0, slots_taken - 1));
      send_item(wdb_pkg::OP_FEED, sl, ow, rl, st, nt);
    end else begin
      send_item(wdb_pkg::OP_QUERY, sl, ow, rl, st, nt);
    end
  endtask

  task automatic test_defaults_after_reset();
    send_item(wdb_pkg::OP_REGISTER, 4'h0, 8'h00, 16'h0000, 16'h0000, 1'b1);
    send_item(wdb_pkg::OP_REGISTER, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(wdb_pkg::OP_QUERY, 4'h0, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_QUERY, 4'h1, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // A slot never registered reads as offline, and a feed to it is ignored.
    send_item(wdb_pkg::OP_FEED, 4'hF, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_QUERY, 4'hF, 8'h00, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_small_default();
    set_default_count(16'd1);
    send_item(wdb_pkg::OP_REGISTER, 4'h0, 8'h5A, 16'h0000, 16'h0000, 1'b1);
    send_item(wdb_pkg::OP_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_QUERY, 4'h2, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_FEED, 4'h2, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_QUERY, 4'h2, 8'h00, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_large_default();
    set_default_count(16'hFFFF);
    send_item(wdb_pkg::OP_REGISTER, 4'h0, 8'hC3, 16'h0000, 16'h0000, 1'b1);
    send_item(wdb_pkg::OP_QUERY, 4'h3, 8'h00, 16'h0000, 16'h0000, 1'b0);
  endtask

  // With a zero default, zero counts stay zero and the slot expires at once.
  task automatic test_zero_default();
    set_default_count(16'h0000);
    send_item(wdb_pkg::OP_REGISTER, 4'h0, 8'h3C, 16'h0000, 16'h0000, 1'b1);
    send_item(wdb_pkg::OP_TICK, 4'h0, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_FEED, 4'h4, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_item(wdb_pkg::OP_QUERY, 4'h4, 8'h00, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: set_default_count(16'($urandom_range(1, 65535)));
        1: set_default_count(16'd1);
        2: set_default_count(16'($urandom_range(2, 8)));
        default: set_default_count(16'hFFFF);
      endcase
      stall_mode = seg % 3;
      sender_steady = (seg == 2);
      for (int n = 0; n < 43; n++) send_random_item(1'b1);
    end
  endtask

  task automatic test_bank_full();
    set_default_count(16'd3);
    stall_mode = 1;
    sender_steady = 0;
    while (slots_taken < NUM_SLOTS)
      send_item(wdb_pkg::OP_REGISTER, 4'($urandom), 8'($urandom), 16'd0, 16'd0, 1'b1);
    send_item(wdb_pkg::OP_REGISTER, 4'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), 1'b1);
    send_item(wdb_pkg::OP_REGISTER, 4'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), 1'b0);
    // Full bank: long ticks under heavy back-pressure.
    stall_mode = 2;
    for (int n = 0; n < 20; n++) send_random_item(1'b1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_after_reset();
    test_small_default();
    test_large_default();
    test_zero_default();
    test_random_traffic();
    test_bank_full();
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
